FILE: rtl/pta_pkg.sv
package pta_pkg;

  // pipeline depth, one register stage per step of the datapath
  localparam int NumStages = 5;

  // channel and blend constants
  localparam int ChW           = 8;
  localparam int ChMax         = 255;
  localparam int AlphaTintMin  = 230;
  localparam int MidLevel      = 128;
  localparam int Percent       = 100;
  localparam int SatNum        = 45;
  localparam int SatShift      = 7;
  localparam int StrengthBase  = 55;
  localparam int CeilNum       = 65;
  localparam int BlendShift    = 8;

  // x / 100 as (x * Recip100) >> Recip100Shift, exact for x below 2**15
  localparam int Recip100      = 5243;
  localparam int Recip100Shift = 19;

  // strength and ceiling for a saturation of zero
  localparam int QRst = 55;
  localparam int MRst = 284;

  localparam int QW = 7;
  localparam int MW = 9;

  typedef enum logic [1:0] {
    RegTintRed   = 2'd0,
    RegTintGreen = 2'd1,
    RegTintBlue  = 2'd2,
    RegTintSat   = 2'd3
  } cfg_reg_e;

  // settings handed from the register block to the channel pipes
  typedef struct packed {
    logic [2:0][ChW-1:0] tint;
    logic [QW-1:0]       q;
    logic [MW-1:0]       m;
  } cfg_t;

endpackage

FILE: rtl/pta_cfg.sv
module pta_cfg (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_addr_i,
  input  logic [pta_pkg::ChW-1:0]  cfg_wdata_i,
  output pta_pkg::cfg_t            cfg_o
);

  logic [2:0][pta_pkg::ChW-1:0] tint_q, tint_d;
  logic [pta_pkg::QW-1:0]       q_q, q_d;
  logic [pta_pkg::MW-1:0]       m_q, m_d;

  logic [13:0]            sat_prod;
  logic [7:0]             q_sum;
  logic [pta_pkg::QW-1:0] q_new;
  logic [pta_pkg::QW-1:0] q_gap;
  logic [11:0]            ceil_prod;
  logic [24:0]            ceil_div;
  logic [pta_pkg::MW-1:0] m_new;

  // strength and ceiling derived from the written saturation
  assign sat_prod  = 14'(cfg_wdata_i) * 14'(pta_pkg::SatNum);
  assign q_sum     = 8'(sat_prod >> pta_pkg::SatShift) + 8'(pta_pkg::StrengthBase);
  assign q_new     = (q_sum > 8'(pta_pkg::Percent)) ? pta_pkg::QW'(pta_pkg::Percent)
                                                    : q_sum[pta_pkg::QW-1:0];
  assign q_gap     = pta_pkg::QW'(pta_pkg::Percent) - q_new;
  assign ceil_prod = 12'(pta_pkg::CeilNum) * 12'(q_gap);
  assign ceil_div  = 25'(ceil_prod) * 25'(pta_pkg::Recip100);
  assign m_new     = pta_pkg::MW'(pta_pkg::ChMax)
                   + pta_pkg::MW'(ceil_div >> pta_pkg::Recip100Shift);

  // register write decode
  always_comb begin
    tint_d = tint_q;
    q_d    = q_q;
    m_d    = m_q;
    if (cfg_we_i) begin
      unique case (pta_pkg::cfg_reg_e'(cfg_addr_i))
        pta_pkg::RegTintRed:   tint_d[0] = cfg_wdata_i;
        pta_pkg::RegTintGreen: tint_d[1] = cfg_wdata_i;
        pta_pkg::RegTintBlue:  tint_d[2] = cfg_wdata_i;
        pta_pkg::RegTintSat: begin
          q_d = q_new;
          m_d = m_new;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tint_q <= '0;
      q_q    <= pta_pkg::QW'(pta_pkg::QRst);
      m_q    <= pta_pkg::MW'(pta_pkg::MRst);
    end else begin
      tint_q <= tint_d;
      q_q    <= q_d;
      m_q    <= m_d;
    end
  end

  assign cfg_o.tint = tint_q;
  assign cfg_o.q    = q_q;
  assign cfg_o.m    = m_q;

endmodule

FILE: rtl/pta_ctrl.sv
module pta_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [pta_pkg::NumStages-1:0] en_o
);

  localparam int N = pta_pkg::NumStages;

  logic [N-1:0] valid_q, valid_d;
  logic [N-1:0] en;

  // a stage loads when it is empty or its word moves on
  always_comb begin
    en[N-1] = !valid_q[N-1] || out_ready_i;
    for (int k = N - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  // valid bits travel with the data
  always_comb begin
    valid_d[0] = en[0] ? in_valid_i : valid_q[0];
    for (int k = 1; k < N; k++) begin
      valid_d[k] = en[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = valid_q[N-1];
  assign en_o        = en;

endmodule

FILE: rtl/pta_chan.sv
module pta_chan (
  input  logic                          clk_i,
  input  logic [pta_pkg::NumStages-1:0] en_i,
  input  logic [pta_pkg::ChW-1:0]       tint_i,
  input  logic [pta_pkg::QW-1:0]        q_i,
  input  logic [pta_pkg::MW-1:0]        m_i,
  input  logic [pta_pkg::ChW-1:0]       pix_i,
  input  logic [pta_pkg::ChW-1:0]       back_i,
  input  logic [pta_pkg::ChW-1:0]       alpha_i,
  output logic [pta_pkg::ChW-1:0]       out_o
);

  // stage 0: tint offset clamped to 0..m
  logic signed [10:0]           raw;
  logic [pta_pkg::MW-1:0]       v_d, v0_q;
  logic [pta_pkg::ChW-1:0]      c0_q, b0_q, a0_q;

  assign raw = $signed({3'b000, tint_i}) + $signed({3'b000, pix_i})
             - 11'(pta_pkg::MidLevel);

  always_comb begin
    if (raw < 11'sd0) begin
      v_d = '0;
    end else if (raw > $signed({2'b00, m_i})) begin
      v_d = m_i;
    end else begin
      v_d = raw[pta_pkg::MW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      v0_q <= v_d;
      c0_q <= pix_i;
      b0_q <= back_i;
      a0_q <= alpha_i;
    end
  end

  // stage 1: weighted sum q*v + (100-q)*c
  logic [pta_pkg::QW-1:0]  q_gap;
  logic [14:0]             sum_d, sum1_q;
  logic [pta_pkg::ChW-1:0] c1_q, b1_q, a1_q;

  assign q_gap = pta_pkg::QW'(pta_pkg::Percent) - q_i;
  assign sum_d = 15'(15'(q_i) * 15'(v0_q)) + 15'(15'(q_gap) * 15'(c0_q));

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      sum1_q <= sum_d;
      c1_q   <= c0_q;
      b1_q   <= b0_q;
      a1_q   <= a0_q;
    end
  end

  // stage 2: divide by 100 through the reciprocal
  logic [27:0]             prod_d, prod2_q;
  logic [pta_pkg::ChW-1:0] c2_q, b2_q, a2_q;

  assign prod_d = 28'(sum1_q) * 28'(pta_pkg::Recip100);

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      prod2_q <= prod_d;
      c2_q    <= c1_q;
      b2_q    <= b1_q;
      a2_q    <= a1_q;
    end
  end

  // stage 3: clamp, bypass for low alpha, scale the difference by alpha
  logic [8:0]              f_div;
  logic [pta_pkg::ChW-1:0] f_tint, f_sel;
  logic signed [9:0]       diff;
  logic signed [19:0]      p_d, p3_q;
  logic [pta_pkg::ChW-1:0] b3_q;

  assign f_div  = prod2_q[27:pta_pkg::Recip100Shift];
  assign f_tint = (f_div > 9'(pta_pkg::ChMax)) ? pta_pkg::ChW'(pta_pkg::ChMax)
                                                : f_div[pta_pkg::ChW-1:0];
  assign f_sel  = (a2_q >= pta_pkg::ChW'(pta_pkg::AlphaTintMin)) ? f_tint : c2_q;
  assign diff   = $signed({2'b00, f_sel}) - $signed({2'b00, b2_q});
  assign p_d    = 20'(diff) * $signed({12'h000, a2_q});

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      p3_q <= p_d;
      b3_q <= b2_q;
    end
  end

  // stage 4: floor shift and add back, output register
  logic signed [19:0]      delta;
  logic [pta_pkg::ChW-1:0] out_d, out_q;

  assign delta = p3_q >>> pta_pkg::BlendShift;
  assign out_d = b3_q + delta[pta_pkg::ChW-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      out_q <= out_d;
    end
  end

  assign out_o = out_q;

endmodule

FILE: rtl/pixel_tint_alpha_blend.sv
// Tints a source pixel toward a programmed color and composites it over a
// background pixel. Takes one word per clock and returns one word per clock
// while m_axis_tready is high; each word passes through the pipeline stages
// (offset clamp, weighted sum, divide by 100, alpha scale, add back) and waits
// longer only while m_axis_tready is held low. Ready chains back through the
// stage valid bits, so empty stages fill even while the output stalls. Register
// writes take effect at the next clock edge and should only happen while no word is in flight.
module pixel_tint_alpha_blend (
  input  logic        clk_i,
  input  logic        rst_ni,

  // register write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [7:0]  cfg_wdata_i,

  // input words
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // pixel_red, pixel_green, pixel_blue, pixel_alpha,
  // back_red, back_green, back_blue, back_alpha
  input  logic [63:0] s_axis_tdata,

  // output words
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_red, out_green, out_blue, out_alpha
  output logic [31:0] m_axis_tdata
);

  localparam int N = pta_pkg::NumStages;

  pta_pkg::cfg_t          cfg;
  logic [N-1:0]           en;
  logic [2:0][7:0]        chan_out;
  logic [N-1:0][7:0]      back_alpha_q;

  pta_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  pta_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .en_o        (en)
  );

  // one pipe per color channel
  for (genvar g = 0; g < 3; g++) begin : g_chan
    pta_chan u_chan (
      .clk_i   (clk_i),
      .en_i    (en),
      .tint_i  (cfg.tint[g]),
      .q_i     (cfg.q),
      .m_i     (cfg.m),
      .pix_i   (s_axis_tdata[8*g +: 8]),
      .back_i  (s_axis_tdata[32 + 8*g +: 8]),
      .alpha_i (s_axis_tdata[31:24]),
      .out_o   (chan_out[g])
    );
  end

  // background alpha rides along unchanged
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      back_alpha_q[0] <= s_axis_tdata[63:56];
    end
    for (int k = 1; k < N; k++) begin
      if (en[k]) begin
        back_alpha_q[k] <= back_alpha_q[k-1];
      end
    end
  end

  assign m_axis_tdata = {back_alpha_q[N-1], chan_out[2], chan_out[1], chan_out[0]};

endmodule

FILE: rtl/pta_checker.sv
module pta_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [63:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  // a stalled output word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output word changed");

  // an open output never blocks the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input blocked while output open");

  // with the output open and no new input the pipe drains
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!s_axis_tvalid && m_axis_tready) ##1 (!s_axis_tvalid && m_axis_tready)
    ##1 (!s_axis_tvalid && m_axis_tready) ##1 (!s_axis_tvalid && m_axis_tready)
    ##1 (!s_axis_tvalid && m_axis_tready) |=> !m_axis_tvalid)
    else $error("word appeared from empty pipe");

  // an accepted word shows up at the output carrying its background alpha while the output stays open
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && m_axis_tready) ##1 m_axis_tready
    ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready
    |=> m_axis_tvalid && (m_axis_tdata[31:24] == $past(s_axis_tdata[63:56], 5)))
    else $error("output word lost or alpha wrong");

endmodule

bind pixel_tint_alpha_blend pta_checker u_pta_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
